// ----- rtl/core/unique_key_stack_macros.svh -----
// Assertion macros shared by the unique key stack RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef UNIQUE_KEY_STACK_MACROS_SVH
`define UNIQUE_KEY_STACK_MACROS_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define UKS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("unique_key_stack: same-cycle check failed");
// Check cons in the cycle after ante.
`define UKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("unique_key_stack: next-cycle check failed");
`else
`define UKS_ASSERT_SAME(label, clk, rst, ante, cons)
`define UKS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/uks_pkg.sv -----
// Shared constants, codes and types of the unique key stack.
// Used by uks_store and unique_key_stack; depends on nothing.
`timescale 1ns / 1ps

package uks_pkg;

  // Capacity of the stack and derived widths
  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  // Operation codes
  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_PEEK = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  // Access request from the sequencer to the key/value store
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

endpackage

// ----- rtl/core/uks_store.sv -----
// Key/value store of the unique key stack: one write port, one read port
// with registered read data. Depends on uks_pkg.
`timescale 1ns / 1ps

module uks_store (
  input  logic                       clk,
  input  uks_pkg::store_req_t        req,
  input  logic [uks_pkg::DATA_W-1:0] wr_key,
  input  logic [uks_pkg::DATA_W-1:0] wr_value,
  output logic [uks_pkg::DATA_W-1:0] rd_key,
  output logic [uks_pkg::DATA_W-1:0] rd_value
);

  logic [uks_pkg::DATA_W-1:0] key_mem   [uks_pkg::DEPTH];
  logic [uks_pkg::DATA_W-1:0] value_mem [uks_pkg::DEPTH];

  // Write the new top pair
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      key_mem[req.wr_addr]   <= wr_key;
      value_mem[req.wr_addr] <= wr_value;
    end
  end

  // Read one entry, data valid the next cycle
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_key   <= key_mem[req.rd_addr];
      rd_value <= value_mem[req.rd_addr];
    end
  end

endmodule

// ----- rtl/core/unique_key_stack.sv -----
// Unique key stack: LIFO of key/value pairs that rejects duplicate keys.
// Push onto an empty stack, underflow and unused codes go straight to the result word;
// pop and peek first read the top entry (S_TOP_RD, S_TOP_DATA); a push onto a non-empty
// stack first runs the key scan, which reads one store entry per cycle over every held
// entry and ends early when the key is found.
// One command word is in flight at a time; the next is taken once its result is registered.
// Synchronous reset empties the stack; store contents stay unknown until written.
`timescale 1ns / 1ps
`include "unique_key_stack_macros.svh"

module unique_key_stack (
  input  logic                        clk,
  input  logic                        rst,
  // command channel
  input  logic                        cmd_valid,
  output logic                        cmd_stall,
  input  logic [1:0]                  kind,
  input  logic signed [31:0]          push_key,
  input  logic signed [31:0]          push_value,
  // response channel
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [1:0]                  status,
  output logic signed [31:0]          top_key,
  output logic signed [31:0]          top_value,
  output logic                        is_empty,
  output logic [uks_pkg::COUNT_W-1:0] entry_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TOP_RD,
    S_TOP_DATA,
    S_RESP
  } state_t;

  state_t                      state;
  logic [uks_pkg::CNT_W-1:0]   fill;
  logic [1:0]                  req_kind;
  logic [uks_pkg::DATA_W-1:0]  req_key;
  logic [uks_pkg::DATA_W-1:0]  req_value;
  logic [1:0]                  res_status;
  logic [uks_pkg::DATA_W-1:0]  res_key;
  logic [uks_pkg::DATA_W-1:0]  res_value;
  logic [uks_pkg::ADDR_W-1:0]  scan_idx;
  logic                        scan_busy;
  logic                        cmp_pend;
  logic                        cmp_last;

  logic                        cmd_acc;
  logic                        rsp_free;
  logic                        fill_zero;
  logic                        fill_full;
  logic [uks_pkg::ADDR_W-1:0]  last_addr;
  logic                        hit;
  logic                        push_now;
  uks_pkg::store_req_t         sreq;
  logic [uks_pkg::DATA_W-1:0]  wr_key;
  logic [uks_pkg::DATA_W-1:0]  wr_value;
  logic [uks_pkg::DATA_W-1:0]  rd_key;
  logic [uks_pkg::DATA_W-1:0]  rd_value;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign fill_zero = (fill == '0);
  assign fill_full = (fill == uks_pkg::CNT_W'(uks_pkg::DEPTH));
  assign last_addr = uks_pkg::ADDR_W'(fill - 1'b1);
  assign hit       = (rd_key == req_key);

  // Decide when a push lands and steer the store ports
  always_comb begin
    push_now = 1'b0;
    wr_key   = req_key;
    wr_value = req_value;
    if (state == S_IDLE) begin
      push_now = cmd_acc && (kind == uks_pkg::KIND_PUSH) && fill_zero;
      wr_key   = push_key;
      wr_value = push_value;
    end else if (state == S_SCAN) begin
      push_now = cmp_pend && !hit && cmp_last && !fill_full;
    end
    sreq.wr_en   = push_now;
    sreq.wr_addr = uks_pkg::ADDR_W'(fill);
    sreq.rd_en   = ((state == S_SCAN) && scan_busy) || (state == S_TOP_RD);
    sreq.rd_addr = (state == S_SCAN) ? scan_idx : last_addr;
  end

  uks_store u_store (
    .clk      (clk),
    .req      (sreq),
    .wr_key   (wr_key),
    .wr_value (wr_value),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  // Sequence each command and hold the response word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rsp_valid <= 1'b0;
      scan_busy <= 1'b0;
      cmp_pend  <= 1'b0;
      cmp_last  <= 1'b0;
    end else begin
      // drop a response word once taken, unless the next one loads now
      if (rsp_valid && !rsp_stall && (state != S_RESP)) begin
        rsp_valid <= 1'b0;
      end
      if (push_now) begin
        fill <= fill + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            req_kind   <= kind;
            req_key    <= push_key;
            req_value  <= push_value;
            res_key    <= '0;
            res_value  <= '0;
            scan_idx   <= '0;
            scan_busy  <= 1'b1;
            cmp_pend   <= 1'b0;
            cmp_last   <= 1'b0;
            case (kind)
              uks_pkg::KIND_PUSH: begin
                res_status <= uks_pkg::ST_DONE;
                state      <= fill_zero ? S_RESP : S_SCAN;
              end
              uks_pkg::KIND_POP, uks_pkg::KIND_PEEK: begin
                if (fill_zero) begin
                  res_status <= uks_pkg::ST_UNDER;
                  state      <= S_RESP;
                end else begin
                  res_status <= uks_pkg::ST_DONE;
                  state      <= S_TOP_RD;
                end
              end
              default: begin
                res_status <= uks_pkg::ST_DONE;
                state      <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          // advance the read pointer over every held entry
          cmp_pend <= scan_busy;
          cmp_last <= scan_busy && (scan_idx == last_addr);
          if (scan_busy) begin
            if (scan_idx == last_addr) begin
              scan_busy <= 1'b0;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
          // compare the entry read last cycle
          if (cmp_pend) begin
            if (hit) begin
              res_status <= uks_pkg::ST_DUP;
              state      <= S_RESP;
            end else if (cmp_last) begin
              res_status <= fill_full ? uks_pkg::ST_OVER : uks_pkg::ST_DONE;
              state      <= S_RESP;
            end
          end
        end
        S_TOP_RD: begin
          state <= S_TOP_DATA;
        end
        S_TOP_DATA: begin
          res_key   <= rd_key;
          res_value <= rd_value;
          if (req_kind == uks_pkg::KIND_POP) begin
            fill <= fill - 1'b1;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (rsp_free) begin
            rsp_valid   <= 1'b1;
            status      <= res_status;
            top_key     <= res_key;
            top_value   <= res_value;
            is_empty    <= fill_zero;
            entry_count <= uks_pkg::COUNT_W'(fill);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `UKS_ASSERT_SAME(a_fill_bound, clk, rst, 1'b1, fill <= uks_pkg::CNT_W'(uks_pkg::DEPTH))
  `UKS_ASSERT_SAME(a_write_room, clk, rst, sreq.wr_en, !fill_full)
  `UKS_ASSERT_SAME(a_scan_nonempty, clk, rst, state == S_SCAN, !fill_zero)
  `UKS_ASSERT_NEXT(a_accept_busy, clk, rst, cmd_acc, state != S_IDLE)

endmodule
